// File: rtl/hyperloglog_sketch_defines.svh
// assertion macros for the checker file hll_checker.sv
`ifndef HYPERLOGLOG_SKETCH_DEFINES_SVH
`define HYPERLOGLOG_SKETCH_DEFINES_SVH

// consequent must hold in the cycle after the antecedent
`define HLL_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define HLL_ASSERT_SAME(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// File: rtl/hll_pkg.sv
package hll_pkg;

    localparam int HASH_BITS = 32;
    localparam int RANK_BITS = 6;
    localparam int SUM_BITS  = 34;
    localparam int EST_BITS  = 32;

    // 0.697 in q16
    localparam logic [15:0] ALPHA_Q16 = 16'd45678;

endpackage

// File: rtl/hll_rank_ram.sv
module hll_rank_ram #(
    parameter int ADDR_BITS = 10
) (
    input  logic                          clk,
    input  logic                          wr_en,
    input  logic [ADDR_BITS-1:0]          wr_addr,
    input  logic [hll_pkg::RANK_BITS-1:0] wr_data,
    input  logic                          rd_en,
    input  logic [ADDR_BITS-1:0]          rd_addr,
    output logic [hll_pkg::RANK_BITS-1:0] rd_data
);
    import hll_pkg::*;

    localparam int DEPTH = 1 << ADDR_BITS;

    logic [RANK_BITS-1:0] mem_reg [DEPTH];
    logic [RANK_BITS-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/hll_divider.sv
module hll_divider #(
    parameter int NUM_BITS = 43
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [NUM_BITS-1:0]          numerator,
    input  logic [hll_pkg::SUM_BITS-1:0] divisor,
    output logic                         done,
    output logic [NUM_BITS-1:0]          quotient
);
    import hll_pkg::*;

    localparam int CNT_BITS = $clog2(NUM_BITS + 1);

    logic [NUM_BITS-1:0] quo_reg, quo_next;
    logic [SUM_BITS-1:0] rem_reg, rem_next;
    logic [SUM_BITS-1:0] den_reg;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;

    logic [SUM_BITS:0]   rem_shift;
    logic [SUM_BITS+1:0] diff;
    logic                fits;

    // one restoring step per cycle
    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[NUM_BITS-1]};
        diff      = {1'b0, rem_shift} - {2'b00, den_reg};
        fits      = !diff[SUM_BITS+1];
    end

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = numerator;
            rem_next  = '0;
            cnt_next  = CNT_BITS'(NUM_BITS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[NUM_BITS-2:0], fits};
            rem_next = fits ? diff[SUM_BITS-1:0] : rem_shift[SUM_BITS-1:0];
            cnt_next = cnt_reg - CNT_BITS'(1);
            if (cnt_reg == CNT_BITS'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (start)
        begin
            den_reg <= divisor;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// File: rtl/hyperloglog_sketch.sv
// channel | direction | handshake           | payload
// --------+-----------+---------------------+----------------------------
// in      | input     | in_valid / in_stall | func, hash_word
// out     | output    | out_valid/out_stall | estimate (query only)
//
// update: ram read, then compare and write (a raised bucket also drops its old
//   weight from the sum), then the sum add only when the bucket is raised
// query: the estimate comes from the bit-serial divider
//   (one quotient bit per cycle over INDEX_BITS+33 bits)
// after reset the ranks ram is swept to zero with in_stall high
// a result waiting on out_stall does not block updates; a second query
//   finishing meanwhile holds until the output register frees up
module hyperloglog_sketch #(
    parameter int INDEX_BITS = 10
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          func,
    input  logic [hll_pkg::HASH_BITS-1:0] hash_word,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [hll_pkg::EST_BITS-1:0]  estimate
);
    import hll_pkg::*;

    // sketch geometry
    localparam int TOP_RANK = HASH_BITS + 1 - INDEX_BITS;
    localparam int NUM_BITS = INDEX_BITS + 33;
    localparam logic [RANK_BITS-1:0] TOP_RANK_R = RANK_BITS'(TOP_RANK);
    localparam logic [HASH_BITS-1:0] LOW_MASK = {HASH_BITS{1'b1}} >> INDEX_BITS;
    // m * 2^TOP_RANK
    localparam logic [SUM_BITS-1:0] SUM_RESET = SUM_BITS'(1) << (INDEX_BITS + TOP_RANK);
    // 0.697 * 2^16 scaled by 2^(INDEX_BITS+17)
    localparam logic [NUM_BITS-1:0] NUMERATOR = NUM_BITS'(ALPHA_Q16) << (INDEX_BITS + 17);

    // sequencer states
    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_CMP   = 3'd2;
    localparam logic [2:0] ST_ADD   = 3'd3;
    localparam logic [2:0] ST_DIV   = 3'd4;
    localparam logic [2:0] ST_HOLD  = 3'd5;

    // trailing zero count, five halving steps
    function automatic logic [4:0] trailing_zeros(input logic [HASH_BITS-1:0] x);
        logic [HASH_BITS-1:0] v;
        logic [4:0]           n;
        v = x;
        n = '0;
        if (v[15:0] == '0)
        begin
            n = n + 5'd16;
            v = v >> 16;
        end
        if (v[7:0] == '0)
        begin
            n = n + 5'd8;
            v = v >> 8;
        end
        if (v[3:0] == '0)
        begin
            n = n + 5'd4;
            v = v >> 4;
        end
        if (v[1:0] == '0)
        begin
            n = n + 5'd2;
            v = v >> 2;
        end
        if (v[0] == 1'b0)
        begin
            n = n + 5'd1;
        end
        return n;
    endfunction

    // 2^-rank in units of 2^-TOP_RANK
    function automatic logic [SUM_BITS-1:0] weight_of(input logic [RANK_BITS-1:0] r);
        logic [RANK_BITS-1:0] rc;
        rc = (r > TOP_RANK_R) ? TOP_RANK_R : r;
        return SUM_BITS'(1) << (TOP_RANK_R - rc);
    endfunction

    logic [2:0]            state_reg, state_next;
    logic [INDEX_BITS-1:0] clr_addr_reg, clr_addr_next;
    logic [INDEX_BITS-1:0] idx_reg;
    logic [RANK_BITS-1:0]  rank_reg;
    logic [SUM_BITS-1:0]   sum_reg, sum_next;
    logic                  out_valid_reg, out_valid_next;
    logic [EST_BITS-1:0]   estimate_reg;

    logic                  in_acc;
    logic [INDEX_BITS-1:0] hash_idx;
    logic [HASH_BITS-1:0]  low_bits;
    logic [RANK_BITS-1:0]  new_rank;
    logic [RANK_BITS-1:0]  old_rank;
    logic                  rank_gt;
    logic                  out_free;
    logic                  load_out;
    logic [EST_BITS-1:0]   est_sat;

    logic                  wr_en;
    logic [INDEX_BITS-1:0] wr_addr;
    logic [RANK_BITS-1:0]  wr_data;
    logic                  div_start;
    logic                  div_done;
    logic [NUM_BITS-1:0]   div_quotient;

    assign in_stall = (state_reg != ST_IDLE);
    assign in_acc   = in_valid && !in_stall;

    // bucket index from the top bits, rank from the rest
    assign hash_idx = hash_word[HASH_BITS-1 -: INDEX_BITS];
    assign low_bits = hash_word & LOW_MASK;
    assign new_rank = (low_bits == '0) ? TOP_RANK_R
                                       : RANK_BITS'(trailing_zeros(low_bits)) + RANK_BITS'(1);

    assign rank_gt = (rank_reg > old_rank);

    // ram write: clearing sweep or a raised bucket
    assign wr_en   = (state_reg == ST_CLEAR) || ((state_reg == ST_CMP) && rank_gt);
    assign wr_addr = (state_reg == ST_CLEAR) ? clr_addr_reg : idx_reg;
    assign wr_data = (state_reg == ST_CLEAR) ? '0 : rank_reg;

    hll_rank_ram #(
        .ADDR_BITS (INDEX_BITS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (in_acc && !func),
        .rd_addr (hash_idx),
        .rd_data (old_rank)
    );

    assign div_start = in_acc && func;

    hll_divider #(
        .NUM_BITS (NUM_BITS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .numerator (NUMERATOR),
        .divisor   (sum_reg),
        .done      (div_done),
        .quotient  (div_quotient)
    );

    // saturate the quotient to 32 bits
    assign est_sat = (div_quotient[NUM_BITS-1:EST_BITS] != '0) ? {EST_BITS{1'b1}}
                                                               : div_quotient[EST_BITS-1:0];

    // output register is free when empty or when its transaction completes
    assign out_free = !out_valid_reg || !out_stall;
    assign load_out = ((state_reg == ST_DIV) && div_done && out_free)
                   || ((state_reg == ST_HOLD) && out_free);

    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        sum_next      = sum_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + INDEX_BITS'(1);
                if (clr_addr_reg == {INDEX_BITS{1'b1}})
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = func ? ST_DIV : ST_CMP;
                end
            end
            ST_CMP:
            begin
                // drop the old weight now, add the new one next cycle
                if (rank_gt)
                begin
                    sum_next   = sum_reg - weight_of(old_rank);
                    state_next = ST_ADD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_ADD:
            begin
                sum_next   = sum_reg + weight_of(rank_reg);
                state_next = ST_IDLE;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = out_free ? ST_IDLE : ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            sum_reg       <= SUM_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_acc && !func)
        begin
            idx_reg  <= hash_idx;
            rank_reg <= new_rank;
        end
        if (load_out)
        begin
            estimate_reg <= est_sat;
        end
    end

    assign out_valid = out_valid_reg;
    assign estimate  = estimate_reg;

endmodule

// File: rtl/hll_checker.sv
`include "hyperloglog_sketch_defines.svh"

module hll_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_stall,
    input logic                         out_valid,
    input logic                         out_stall,
    input logic [hll_pkg::EST_BITS-1:0] estimate
);
    import hll_pkg::*;

    // every accepted transaction leaves the block busy in the cycle after the accept
    `HLL_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "no busy cycle after accept")

    // results are only produced by the sequencer while busy
    `HLL_ASSERT_SAME(a_result_while_busy, $rose(out_valid), $past(in_stall), "result rose while idle")

    // a stalled result holds
    `HLL_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(estimate), "stalled result changed")

endmodule

bind hyperloglog_sketch hll_checker u_hll_checker (.*);
